### src/frq_pkg.sv
`timescale 1ns / 1ps
// Package for the ready queue: command, status and state codes, field widths
// and default sizes. It depends on nothing; the top level and testbench use it.
package frq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_W            = 8;
  localparam int unsigned COUNT_W         = 5;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN,
    S_SHIFT
  } state_e;

endpackage

### src/fifo_ready_queue_with_remove_unit.sv
`timescale 1ns / 1ps
// Top level of the ready queue of thread ids: control sequencer around one RAM.
// It depends on frq_pkg and frq_ram.
//
// A command is taken when start is high and busy is low, and its one result
// appears for a single cycle with done_o high; the receiver cannot stall it.
// The ids sit in a circular buffer in one RAM with a head pointer and a count,
// and the single RAM read port sets the timing. Add and every command on an
// empty queue give their result straight from the idle state; dequeue first
// reads the head entry. Query and remove scan from the head one entry per cycle
// and stop at the first hit or after the last entry. Remove then closes the gap
// by moving every later entry down one place, one per cycle, and gives its
// result once every later entry has moved. A command may be taken in the cycle
// its predecessor's result is shown.
module fifo_ready_queue_with_remove_unit #(
  parameter int unsigned QUEUE_DEPTH = frq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command_i,
  input  logic [frq_pkg::ID_W-1:0]     thread_id_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic                         found_o,
  output logic [frq_pkg::ID_W-1:0]     out_thread_id_o,
  output logic [frq_pkg::COUNT_W-1:0]  queue_count_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  frq_pkg::state_e  state_q, state_d;
  frq_pkg::cmd_e    cmd_q, cmd_d;
  frq_pkg::status_e status_q, status_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    pidx_q, pidx_d;
  logic             pend_q, pend_d;
  logic [frq_pkg::ID_W-1:0] id_q, id_d;
  logic             done_q, done_d;
  logic             found_q, found_d;
  logic [frq_pkg::ID_W-1:0] tid_q, tid_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [frq_pkg::ID_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [frq_pkg::ID_W-1:0] ram_rdata;

  logic             accept;
  logic             is_empty;
  logic             is_full;
  logic             issue;
  logic             hit;
  logic             last;
  logic [CW+frq_pkg::COUNT_W-1:0] count_ext;

  frq_ram #(
    .WIDTH (frq_pkg::ID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy     = (state_q != frq_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CW'(QUEUE_DEPTH));
  assign issue    = (idx_q < count_q);
  assign hit      = pend_q && (ram_rdata == id_q);
  assign last     = (CW'(pidx_q + 1'b1) == count_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (frq_pkg::cmd_e'(command_i))
            frq_pkg::CMD_ADD:     state_d = frq_pkg::S_IDLE;
            frq_pkg::CMD_DEQUEUE: state_d = is_empty ? frq_pkg::S_IDLE : frq_pkg::S_DEQ;
            frq_pkg::CMD_REMOVE,
            frq_pkg::CMD_QUERY:   state_d = is_empty ? frq_pkg::S_IDLE : frq_pkg::S_SCAN;
            default:              state_d = frq_pkg::S_IDLE;
          endcase
        end
      end
      frq_pkg::S_DEQ: begin
        state_d = frq_pkg::S_IDLE;
      end
      frq_pkg::S_SCAN: begin
        priority if (hit) begin
          state_d = (cmd_q == frq_pkg::CMD_REMOVE) ? frq_pkg::S_SHIFT : frq_pkg::S_IDLE;
        end else if (pend_q && last) begin
          state_d = frq_pkg::S_IDLE;
        end else begin
          state_d = frq_pkg::S_SCAN;
        end
      end
      frq_pkg::S_SHIFT: begin
        if (!issue && !pend_q) begin
          state_d = frq_pkg::S_IDLE;
        end
      end
      default: state_d = frq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d     = cmd_q;
    id_d      = id_q;
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pidx_d    = pidx_q;
    pend_d    = pend_q;
    done_d    = 1'b0;
    status_d  = frq_pkg::ST_OK;
    found_d   = 1'b0;
    tid_d     = '0;
    ram_we    = 1'b0;
    ram_waddr = phys(head_q, count_q);
    ram_wdata = id_q;
    ram_raddr = phys(head_q, idx_q);
    unique case (state_q)
      frq_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d  = frq_pkg::cmd_e'(command_i);
          id_d   = thread_id_i;
          idx_d  = '0;
          pend_d = 1'b0;
          unique case (frq_pkg::cmd_e'(command_i))
            frq_pkg::CMD_ADD: begin
              done_d = 1'b1;
              if (is_full) begin
                status_d = frq_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = thread_id_i;
                count_d   = CW'(count_q + 1'b1);
              end
            end
            frq_pkg::CMD_DEQUEUE: begin
              ram_raddr = head_q;
              if (is_empty) begin
                done_d   = 1'b1;
                status_d = frq_pkg::ST_EMPTY;
              end
            end
            frq_pkg::CMD_REMOVE,
            frq_pkg::CMD_QUERY: begin
              if (is_empty) begin
                done_d   = 1'b1;
                status_d = frq_pkg::ST_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
      end
      frq_pkg::S_DEQ: begin
        done_d  = 1'b1;
        tid_d   = ram_rdata;
        head_d  = phys(head_q, CW'(1));
        count_d = CW'(count_q - 1'b1);
      end
      frq_pkg::S_SCAN: begin
        if (issue) begin
          idx_d = CW'(idx_q + 1'b1);
        end
        pend_d = issue;
        pidx_d = idx_q;
        priority if (hit) begin
          if (cmd_q == frq_pkg::CMD_REMOVE) begin
            idx_d  = CW'(pidx_q + 1'b1);
            pend_d = 1'b0;
          end else begin
            done_d  = 1'b1;
            found_d = 1'b1;
          end
        end else if (pend_q && last) begin
          done_d   = 1'b1;
          status_d = frq_pkg::ST_NOT_FOUND;
        end else begin
          done_d = 1'b0;
        end
      end
      frq_pkg::S_SHIFT: begin
        if (issue) begin
          idx_d = CW'(idx_q + 1'b1);
        end
        pend_d = issue;
        pidx_d = idx_q;
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_q, CW'(pidx_q - 1'b1));
          ram_wdata = ram_rdata;
        end
        if (!issue && !pend_q) begin
          count_d = CW'(count_q - 1'b1);
          done_d  = 1'b1;
          found_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frq_pkg::S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    id_q     <= id_d;
    idx_q    <= idx_d;
    pidx_q   <= pidx_d;
    status_q <= status_d;
    found_q  <= found_d;
    tid_q    <= tid_d;
  end

  assign count_ext       = {{frq_pkg::COUNT_W{1'b0}}, count_q};
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign found_o         = found_q;
  assign out_thread_id_o = tid_q;
  assign queue_count_o   = count_ext[frq_pkg::COUNT_W-1:0];

endmodule

### src/frq_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// It depends on nothing.
module frq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### tb/sv/tb_fifo_ready_queue_with_remove_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for fifo_ready_queue_with_remove_unit: a queue-driven
// command driver, a result monitor and a built-in ready-queue predictor.
// It depends on frq_pkg and the RTL of the unit.
module tb_fifo_ready_queue_with_remove_unit;
  import frq_pkg::*;

  localparam int unsigned DEPTH       = QUEUE_DEPTH_DEF;
  localparam int          N_ITEMS     = 1700;
  localparam int          N_QUIET     = 300;
  localparam int          SEG_LEN     = 50;
  localparam int          TAIL_CYCLES = 40;

  typedef struct packed {
    cmd_e            cmd;
    logic [ID_W-1:0] id;
    logic [3:0]      gap;
    logic            drain;
  } sched_cmd_t;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] count;
  } sched_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic [1:0]         command_i   = CMD_ADD;
  logic [ID_W-1:0]    thread_id_i = '0;
  logic               busy;
  logic               done_o;
  logic [1:0]         status_o;
  logic               found_o;
  logic [ID_W-1:0]    out_thread_id_o;
  logic [COUNT_W-1:0] queue_count_o;

  sched_cmd_t      cmd_backlog[$];
  sched_result_t   awaited_results[$];
  logic [ID_W-1:0] model_ids[$];
  sched_cmd_t      next_cmd;
  sched_result_t   oldest_result;
  int              idle_left  = 0;
  int              n_accepted = 0;
  int              n_checked  = 0;
  int              errors     = 0;

  fifo_ready_queue_with_remove_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .thread_id_i    (thread_id_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .found_o        (found_o),
    .out_thread_id_o(out_thread_id_o),
    .queue_count_o  (queue_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic sched_result_t apply_command(cmd_e cmd, logic [ID_W-1:0] id);
    sched_result_t r;
    int            slot;
    r    = '{status: ST_OK, found: 1'b0, id: '0, count: '0};
    slot = -1;
    case (cmd)
      CMD_ADD: begin
        if (model_ids.size() >= DEPTH) r.status = ST_FULL;
        else model_ids.push_back(id);
      end
      CMD_DEQUEUE: begin
        if (model_ids.size() == 0) r.status = ST_EMPTY;
        else r.id = model_ids.pop_front();
      end
      default: begin
        for (int i = 0; i < model_ids.size(); i++)
          if (slot < 0 && model_ids[i] == id) slot = i;
        if (slot < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          if (cmd == CMD_REMOVE) model_ids.delete(slot);
        end
      end
    endcase
    r.count = COUNT_W'(model_ids.size());
    return r;
  endfunction

  task automatic queue_cmd(cmd_e cmd, logic [ID_W-1:0] id, int gap, bit drain);
    cmd_backlog.push_back('{cmd: cmd, id: id, gap: 4'(gap), drain: drain});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      command_i   <= CMD_ADD;
      thread_id_i <= '0;
      idle_left   = 0;
    end else begin
      if (start && !busy) begin
        awaited_results.push_back(apply_command(cmd_e'(command_i), thread_id_i));
        n_accepted++;
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (cmd_backlog.size() != 0 && cmd_backlog[0].gap != 0) begin
          idle_left          = int'(cmd_backlog[0].gap) - 1;
          cmd_backlog[0].gap = '0;
          start <= 1'b0;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].drain && n_checked != n_accepted)) begin
          next_cmd = cmd_backlog.pop_front();
          start       <= 1'b1;
          command_i   <= next_cmd.cmd;
          thread_id_i <= next_cmd.id;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_checked <= 0;
    end else if (done_o) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status=%0d found=%0d id=%0d count=%0d",
                 $time, status_o, found_o, out_thread_id_o, queue_count_o);
        errors++;
      end else begin
        oldest_result = awaited_results.pop_front();
        n_checked <= n_checked + 1;
        if (status_o !== oldest_result.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, oldest_result.status, status_o);
          errors++;
        end
        if (found_o !== oldest_result.found) begin
          $display("%0t: found mismatch: expected %0d, actual %0d",
                   $time, oldest_result.found, found_o);
          errors++;
        end
        if (out_thread_id_o !== oldest_result.id) begin
          $display("%0t: out_thread_id mismatch: expected %0d, actual %0d",
                   $time, oldest_result.id, out_thread_id_o);
          errors++;
        end
        if (queue_count_o !== oldest_result.count) begin
          $display("%0t: queue_count mismatch: expected %0d, actual %0d",
                   $time, oldest_result.count, queue_count_o);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [ID_W-1:0] id_pool[6];
    int              add_pct;
    bit              idles_on;
    int              gap;
    cmd_e            cmd;
    logic [ID_W-1:0] id;

    // Directed part: empty-queue cases, a full fill with one duplicate, overflow,
    // a query miss, removal of tail and oldest duplicate, head dequeue, a query.
    queue_cmd(CMD_DEQUEUE, 8'h00, 0, 1'b0);
    queue_cmd(CMD_REMOVE, 8'hFF, 0, 1'b0);
    queue_cmd(CMD_QUERY, 8'h00, 0, 1'b0);
    for (int k = 0; k < DEPTH; k++)
      queue_cmd(CMD_ADD, (k == 8) ? 8'h33 : ID_W'(k * 17), 0, 1'b0);
    queue_cmd(CMD_ADD, 8'hA5, 0, 1'b0);
    queue_cmd(CMD_QUERY, 8'h5A, 0, 1'b0);
    queue_cmd(CMD_REMOVE, 8'hFF, 0, 1'b0);
    queue_cmd(CMD_REMOVE, 8'h33, 0, 1'b0);
    queue_cmd(CMD_DEQUEUE, 8'hFF, 0, 1'b0);
    queue_cmd(CMD_QUERY, 8'h33, 0, 1'b0);

    for (int n = cmd_backlog.size(); n < N_ITEMS; n++) begin
      if ((n % SEG_LEN) == 0 || n == 25) begin
        add_pct  = 15 + 15 * $urandom_range(0, 4);
        idles_on = ($urandom_range(0, 2) != 0);
        foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 99) < add_pct) cmd = CMD_ADD;
      else cmd = cmd_e'($urandom_range(1, 3));
      if ($urandom_range(0, 9) < 7) id = id_pool[$urandom_range(0, 5)];
      else id = ID_W'($urandom_range(0, 255));
      gap = 0;
      if (idles_on && n < N_ITEMS - N_QUIET && $urandom_range(0, 3) == 0)
        gap = $urandom_range(1, 10);
      queue_cmd(cmd, id, gap,
                n == 25 || ((n % SEG_LEN) == 0 && $urandom_range(0, 3) == 0));
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_backlog.size() != 0 || start || n_checked != n_accepted)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (errors == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d transactions still awaited", $time,
             awaited_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
src/frq_pkg.sv
src/frq_ram.sv
src/fifo_ready_queue_with_remove_unit.sv
tb/sv/tb_fifo_ready_queue_with_remove_unit.sv
